// ----- rtl/rc_link_frame_parser_macros.svh -----
// Assertion macros used by the parser top level.
`ifndef RC_LINK_FRAME_PARSER_MACROS_SVH
`define RC_LINK_FRAME_PARSER_MACROS_SVH

`ifndef ASSERT_OFF

// The consequent must hold in the same cycle as the antecedent.
`define RCLFP_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("rclfp assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define RCLFP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("rclfp assertion failed");

`else

`define RCLFP_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define RCLFP_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ----- rtl/rclfp_pkg.sv -----
`default_nettype none

package rclfp_pkg;

    localparam int MAX_FRAME_DEF = 64;
    localparam int CHANNELS_DEF  = 16;

    localparam logic [7:0] SYNC_BYTE   = 8'hC8;
    localparam logic [7:0] TYPE_RC     = 8'h16;
    localparam logic [7:0] CRC_POLY    = 8'hD5;
    localparam logic [7:0] MIN_LEN     = 8'd24;   // type byte + 22 payload bytes + CRC
    localparam logic [7:0] MIN_BODY    = 8'd2;

    localparam int         RAW_W       = 11;
    localparam logic [10:0] RAW_LO     = 11'd172;
    localparam logic [10:0] RAW_HI     = 11'd1811;
    localparam logic [10:0] PULSE_BASE = 11'd1000;

    // floor(y * 1000 / 1639) == (y * SCALE_MUL) >> SCALE_SHIFT for y in 0..1639.
    localparam int          SCALE_SHIFT = 22;
    localparam logic [21:0] SCALE_MUL   = 22'd2559063;
    localparam int          PROD_W      = RAW_W + SCALE_SHIFT;

    localparam int ACC_W = 18;   // at most 10 leftover bits plus one byte
    localparam int CNT_W = 5;

    typedef struct packed {
        logic load_len;
        logic store_body;
        logic start_unpack;
        logic rd_issue;
        logic rd_load;
        logic mul;
        logic emit;
    } t_ctrl_cmd;

    typedef struct packed {
        logic is_sync;
        logic len_ok;
        logic body_last;
        logic frame_good;
        logic bits_ready;
        logic last_chan;
        logic out_free;
    } t_dp_status;

    function automatic logic [7:0] crc_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/rclfp_ram.sv -----
`default_nettype none

module rclfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire                      i_clk,
    input  wire                      i_wr_en,
    input  wire  [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire  [WIDTH-1:0]         i_wr_data,
    input  wire                      i_rd_en,
    input  wire  [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/rclfp_ctrl.sv -----
`default_nettype none

module rclfp_ctrl (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_rx_valid,
    output logic                  o_rx_ready,
    input  rclfp_pkg::t_dp_status i_stat,
    output rclfp_pkg::t_ctrl_cmd  o_cmd
);

    typedef enum logic [2:0] {
        ST_SYNC,
        ST_LEN,
        ST_BODY,
        ST_FETCH,
        ST_LOAD,
        ST_MUL,
        ST_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   rx_take;

    assign o_rx_ready = (r_state == ST_SYNC) || (r_state == ST_LEN) || (r_state == ST_BODY);
    assign rx_take    = i_rx_valid && o_rx_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_SYNC: begin
                if (rx_take && i_stat.is_sync) begin
                    n_state = ST_LEN;
                end
            end
            ST_LEN: begin
                if (rx_take) begin
                    o_cmd.load_len = 1'b1;
                    n_state = i_stat.len_ok ? ST_BODY : ST_SYNC;
                end
            end
            ST_BODY: begin
                if (rx_take) begin
                    o_cmd.store_body = 1'b1;
                    if (i_stat.body_last) begin
                        if (i_stat.frame_good) begin
                            o_cmd.start_unpack = 1'b1;
                            n_state = ST_FETCH;
                        end else begin
                            n_state = ST_SYNC;
                        end
                    end
                end
            end
            ST_FETCH: begin
                if (i_stat.bits_ready) begin
                    n_state = ST_MUL;
                end else begin
                    o_cmd.rd_issue = 1'b1;
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                o_cmd.rd_load = 1'b1;
                n_state = ST_FETCH;
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state = i_stat.last_chan ? ST_SYNC : ST_FETCH;
                end
            end
            default: begin
                n_state = ST_SYNC;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_SYNC;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/rclfp_dpath.sv -----
`default_nettype none

module rclfp_dpath #(
    parameter int MAX_FRAME = rclfp_pkg::MAX_FRAME_DEF,
    parameter int CHANNELS  = rclfp_pkg::CHANNELS_DEF
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire  [7:0]            i_rx_byte,
    input  rclfp_pkg::t_ctrl_cmd  i_cmd,
    output rclfp_pkg::t_dp_status o_stat,
    input  wire                   i_out_ready,
    output logic                  o_out_valid,
    output logic [3:0]            o_channel_index,
    output logic [10:0]           o_pulse_us,
    output logic                  o_last_channel
);

    localparam int AW = $clog2(MAX_FRAME);

    logic [7:0]                       r_len;
    logic [7:0]                       r_count;
    logic [7:0]                       r_crc;
    logic                             r_type_ok;
    logic [rclfp_pkg::ACC_W-1:0]      r_acc;
    logic [rclfp_pkg::CNT_W-1:0]      r_bit_cnt;
    logic [AW-1:0]                    r_rd_addr;
    logic [3:0]                       r_chan;
    logic [9:0]                       r_scaled;
    logic                             r_out_valid;

    logic [7:0]                       ram_rd_data;
    logic [8:0]                       count_inc;
    logic [10:0]                      raw;
    logic [10:0]                      clamped;
    logic [10:0]                      offset;
    logic [rclfp_pkg::PROD_W-1:0]     prod;

    rclfp_ram #(
        .WIDTH (8),
        .DEPTH (MAX_FRAME)
    ) u_body_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.store_body),
        .i_wr_addr (r_count[AW-1:0]),
        .i_wr_data (i_rx_byte),
        .i_rd_en   (i_cmd.rd_issue),
        .i_rd_addr (r_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    assign count_inc = {1'b0, r_count} + 9'd1;

    assign o_stat.is_sync    = (i_rx_byte == rclfp_pkg::SYNC_BYTE);
    assign o_stat.len_ok     = (i_rx_byte >= rclfp_pkg::MIN_BODY) && (i_rx_byte <= 8'(MAX_FRAME));
    assign o_stat.body_last  = (count_inc >= {1'b0, r_len});
    assign o_stat.frame_good = (r_crc == i_rx_byte) && r_type_ok && (r_len >= rclfp_pkg::MIN_LEN);
    assign o_stat.bits_ready = (r_bit_cnt >= rclfp_pkg::CNT_W'(rclfp_pkg::RAW_W));
    assign o_stat.last_chan  = (r_chan == 4'(CHANNELS - 1));
    assign o_stat.out_free   = !r_out_valid || i_out_ready;

    // Clamp to the valid stick range, then scale by a reciprocal multiply.
    assign raw     = r_acc[rclfp_pkg::RAW_W-1:0];
    assign clamped = (raw < rclfp_pkg::RAW_LO) ? rclfp_pkg::RAW_LO :
                     (raw > rclfp_pkg::RAW_HI) ? rclfp_pkg::RAW_HI : raw;
    assign offset  = clamped - rclfp_pkg::RAW_LO;
    assign prod    = rclfp_pkg::PROD_W'(offset) * rclfp_pkg::PROD_W'(rclfp_pkg::SCALE_MUL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_count     <= '0;
            r_crc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load_len) begin
                r_len   <= i_rx_byte;
                r_count <= '0;
                r_crc   <= '0;
            end
            if (i_cmd.store_body) begin
                r_count <= count_inc[7:0];
                if (!o_stat.body_last) begin
                    r_crc <= rclfp_pkg::crc_update(r_crc, i_rx_byte);
                end
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.store_body && (r_count == 8'd0)) begin
            r_type_ok <= (i_rx_byte == rclfp_pkg::TYPE_RC);
        end
        if (i_cmd.start_unpack) begin
            r_acc     <= '0;
            r_bit_cnt <= '0;
            r_rd_addr <= AW'(1);
            r_chan    <= '0;
        end
        if (i_cmd.rd_load) begin
            // Payload bits are packed LSB first, so new bytes land above the leftovers.
            r_acc     <= r_acc | (rclfp_pkg::ACC_W'(ram_rd_data) << r_bit_cnt);
            r_bit_cnt <= r_bit_cnt + rclfp_pkg::CNT_W'(8);
            r_rd_addr <= r_rd_addr + AW'(1);
        end
        if (i_cmd.mul) begin
            r_scaled  <= prod[rclfp_pkg::SCALE_SHIFT +: 10];
            r_acc     <= r_acc >> rclfp_pkg::RAW_W;
            r_bit_cnt <= r_bit_cnt - rclfp_pkg::CNT_W'(rclfp_pkg::RAW_W);
        end
        if (i_cmd.emit) begin
            o_channel_index <= r_chan;
            o_pulse_us      <= rclfp_pkg::PULSE_BASE + {1'b0, r_scaled};
            o_last_channel  <= o_stat.last_chan;
            r_chan          <= r_chan + 4'd1;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// ----- rtl/rc_link_frame_parser.sv -----
// RC link frame parser.
// Input channel: one received byte per request on i_rx_byte, handshaken by
// i_rx_valid and o_rx_ready. Output channel: one decoded RC channel per request
// (o_channel_index, o_pulse_us, o_last_channel), handshaken by o_out_valid and
// i_out_ready; o_last_channel marks the final channel of a frame.
// While hunting for sync or receiving a frame, the block takes every byte offered,
// including the byte that completes a frame. After a frame passes its CRC, type
// and length checks, the block stops taking bytes and unpacks the channels from
// the body memory, which has one read port: for each channel it fetches body
// bytes, each through a read issue step and a load step, until enough bits are
// held, then takes one multiply step and one output step.
// The hunt resumes once the last channel is handed to the output register,
// while that result may still wait to be taken.
// A stalled receiver holds the pending result and the unpacking pauses.
// Reset returns the parser to the sync hunt with no result pending; the body
// memory needs no clearing.
`default_nettype none

`include "rc_link_frame_parser_macros.svh"

module rc_link_frame_parser #(
    parameter int MAX_FRAME = rclfp_pkg::MAX_FRAME_DEF,
    parameter int CHANNELS  = rclfp_pkg::CHANNELS_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_rx_valid,
    output logic        o_rx_ready,
    input  wire  [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  wire         i_out_ready,
    output logic [3:0]  o_channel_index,
    output logic [10:0] o_pulse_us,
    output logic        o_last_channel
);

    rclfp_pkg::t_ctrl_cmd  w_cmd;
    rclfp_pkg::t_dp_status w_stat;

    rclfp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx_valid (i_rx_valid),
        .o_rx_ready (o_rx_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    rclfp_dpath #(
        .MAX_FRAME (MAX_FRAME),
        .CHANNELS  (CHANNELS)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_rx_byte       (i_rx_byte),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_out_ready     (i_out_ready),
        .o_out_valid     (o_out_valid),
        .o_channel_index (o_channel_index),
        .o_pulse_us      (o_pulse_us),
        .o_last_channel  (o_last_channel)
    );

    // A result is only loaded into an output register that is free.
    `RCLFP_ASSERT_SAME(a_emit_free, i_clk, i_rst_n, w_cmd.emit, w_stat.out_free)
    // Memory data is consumed the cycle after its read is issued.
    `RCLFP_ASSERT_NEXT(a_read_load, i_clk, i_rst_n, w_cmd.rd_issue, w_cmd.rd_load)
    // After the last channel the parser is back hunting for sync.
    `RCLFP_ASSERT_NEXT(a_last_hunt, i_clk, i_rst_n, w_cmd.emit && w_stat.last_chan, o_rx_ready)

endmodule

`default_nettype wire

// ----- dv/rc_link_frame_parser_tb.sv -----
`timescale 1ns / 100ps

// Tracks the parser state byte by byte and keeps the channel values that a
// decoded frame is due to produce, oldest first.
class rc_frame_scoreboard;

    typedef enum logic [1:0] {HUNT, GET_LEN, GET_BODY} t_phase;

    typedef struct packed {
        logic [3:0]  idx;
        logic [10:0] pulse;
        logic        last;
    } t_chan;

    t_phase      phase;
    logic [7:0]  flen;
    logic [7:0]  nbody;
    logic [7:0]  crc;
    logic [7:0]  body [rclfp_pkg::MAX_FRAME_DEF];
    t_chan       expected_chans [$];
    int unsigned predicted_total;
    int unsigned err_count;

    function new();
        phase = HUNT;
        flen = '0;
        nbody = '0;
        crc = '0;
        predicted_total = 0;
        err_count = 0;
    endfunction

    static function logic [7:0] crc_step(logic [7:0] c, logic [7:0] b);
        logic [7:0] r;
        r = c ^ b;
        repeat (8) begin
            r = r[7] ? ({r[6:0], 1'b0} ^ rclfp_pkg::CRC_POLY) : {r[6:0], 1'b0};
        end
        return r;
    endfunction

    static function logic [10:0] to_pulse(logic [10:0] raw);
        int unsigned r;
        int unsigned lo;
        int unsigned hi;
        lo = rclfp_pkg::RAW_LO;
        hi = rclfp_pkg::RAW_HI;
        r = raw;
        if (r < lo) r = lo;
        if (r > hi) r = hi;
        return 11'(int'(rclfp_pkg::PULSE_BASE) + ((r - lo) * 1000) / (hi - lo));
    endfunction

    function int unsigned pending();
        return expected_chans.size();
    endfunction

    // Channel ch starts at payload bit 11*ch, LSB first; the payload starts
    // right after the type byte.
    function void unpack_frame();
        logic [23:0] win;
        logic [10:0] raw;
        int unsigned bitpos;
        int unsigned pos;
        t_chan e;
        for (int ch = 0; ch < rclfp_pkg::CHANNELS_DEF; ch++) begin
            bitpos = ch * 11;
            pos = 1 + bitpos / 8;
            win = {body[pos + 2], body[pos + 1], body[pos]};
            raw = win[bitpos % 8 +: 11];
            e.idx = 4'(ch);
            e.pulse = to_pulse(raw);
            e.last = (ch == rclfp_pkg::CHANNELS_DEF - 1);
            expected_chans.push_back(e);
            predicted_total++;
        end
    endfunction

    function void note_byte(logic [7:0] b);
        case (phase)
            HUNT: begin
                if (b == rclfp_pkg::SYNC_BYTE) phase = GET_LEN;
            end
            GET_LEN: begin
                flen = b;
                nbody = '0;
                crc = '0;
                if (b < rclfp_pkg::MIN_BODY || b > rclfp_pkg::MAX_FRAME_DEF) phase = HUNT;
                else phase = GET_BODY;
            end
            GET_BODY: begin
                body[nbody] = b;
                nbody = nbody + 8'd1;
                if (nbody >= flen) begin
                    if (crc == b && body[0] == rclfp_pkg::TYPE_RC &&
                        flen >= rclfp_pkg::MIN_LEN) begin
                        unpack_frame();
                    end
                    phase = HUNT;
                end else begin
                    crc = crc_step(crc, b);
                end
            end
            default: phase = HUNT;
        endcase
    endfunction

    task flag_mismatch(string msg);
        $display("ERROR at %0t: %s", $time, msg);
        err_count++;
    endtask

    task check_result(logic [3:0] idx, logic [10:0] pulse, logic last);
        t_chan e;
        if (expected_chans.size() == 0) begin
            flag_mismatch($sformatf("unexpected channel %0d pulse %0d last %0b",
                                    idx, pulse, last));
            return;
        end
        e = expected_chans.pop_front();
        if (idx !== e.idx)
            flag_mismatch($sformatf("channel_index %0d, expected %0d", idx, e.idx));
        if (pulse !== e.pulse)
            flag_mismatch($sformatf("pulse_us %0d on channel %0d, expected %0d",
                                    pulse, e.idx, e.pulse));
        if (last !== e.last)
            flag_mismatch($sformatf("last_channel %0b on channel %0d, expected %0b",
                                    last, e.idx, e.last));
    endtask

endclass

module rc_link_frame_parser_tb;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_rx_valid;
    logic        o_rx_ready;
    logic [7:0]  i_rx_byte;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [3:0]  o_channel_index;
    logic [10:0] o_pulse_us;
    logic        o_last_channel;

    rc_frame_scoreboard chan_sb;

    logic [10:0] frame_chans [rclfp_pkg::CHANNELS_DEF];
    int unsigned sent_bytes;
    bit          tx_steady;
    bit          hold_armed;
    bit          hold_done;

    rc_link_frame_parser dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_rx_valid      (i_rx_valid),
        .o_rx_ready      (o_rx_ready),
        .i_rx_byte       (i_rx_byte),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_channel_index (o_channel_index),
        .o_pulse_us      (o_pulse_us),
        .o_last_channel  (o_last_channel)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #400000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (tx_steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    // Mostly arbitrary 11-bit values, with the clamp edges mixed in.
    function automatic logic [10:0] pick_raw();
        if ($urandom_range(0, 9) < 6) return 11'($urandom_range(0, 2047));
        case ($urandom_range(0, 7))
            0: return 11'd0;
            1: return 11'd171;
            2: return 11'd172;
            3: return 11'd173;
            4: return 11'd1810;
            5: return 11'd1811;
            6: return 11'd1812;
            default: return 11'd2047;
        endcase
    endfunction

    task automatic fill_chans();
        for (int ch = 0; ch < rclfp_pkg::CHANNELS_DEF; ch++) frame_chans[ch] = pick_raw();
    endtask

    // Returns just after the rising edge at which the request was taken.
    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        gap = pick_gap();
        @(negedge i_clk);
        for (int k = 0; k < gap; k++) begin
            i_rx_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_rx_valid <= 1'b1;
        i_rx_byte <= b;
        forever begin
            @(posedge i_clk);
            if (o_rx_ready) break;
        end
        chan_sb.note_byte(b);
        sent_bytes++;
    endtask

    // Sends sync, length and the first nsend body bytes of a frame carrying
    // frame_chans. Payload bytes past the channel data are random or sync bytes.
    task automatic send_frame(input logic [7:0] flen, input logic [7:0] ftype,
                              input bit bad_crc, input int unsigned nsend,
                              input bit sync_fill);
        logic [7:0]   body [rclfp_pkg::MAX_FRAME_DEF];
        logic [175:0] bits;
        logic [7:0]   c;
        bits = '0;
        for (int ch = 0; ch < rclfp_pkg::CHANNELS_DEF; ch++) bits[ch * 11 +: 11] = frame_chans[ch];
        body[0] = ftype;
        for (int i = 1; i + 1 < flen; i++) begin
            if (i <= 22) body[i] = bits[(i - 1) * 8 +: 8];
            else body[i] = sync_fill ? rclfp_pkg::SYNC_BYTE : 8'($urandom_range(0, 255));
        end
        c = '0;
        for (int i = 0; i + 1 < flen; i++) c = chan_sb.crc_step(c, body[i]);
        body[flen - 1] = bad_crc ? (c ^ 8'($urandom_range(1, 255))) : c;
        send_byte(rclfp_pkg::SYNC_BYTE);
        send_byte(flen);
        for (int i = 0; i < nsend; i++) send_byte(body[i]);
    endtask

    task automatic run_directed();
        logic [10:0] corners [16] = '{11'd0, 11'd2047, 11'd171, 11'd172, 11'd173,
                                      11'd1810, 11'd1811, 11'd1812, 11'd1, 11'd1024,
                                      11'd2046, 11'd1000, 11'd1500, 11'd300,
                                      11'd1700, 11'd0};
        // Noise and bad lengths; a sync in the length slot is a bad length too.
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h5A);
        send_byte(rclfp_pkg::SYNC_BYTE); send_byte(8'd0);
        send_byte(rclfp_pkg::SYNC_BYTE); send_byte(8'd1);
        send_byte(rclfp_pkg::SYNC_BYTE); send_byte(8'(rclfp_pkg::MAX_FRAME_DEF + 1));
        send_byte(rclfp_pkg::SYNC_BYTE); send_byte(8'hFF);
        send_byte(rclfp_pkg::SYNC_BYTE); send_byte(rclfp_pkg::SYNC_BYTE);
        send_byte(8'h03);
        // Good frame with clamp corners and sync bytes inside the body.
        frame_chans = corners;
        send_frame(8'd26, rclfp_pkg::TYPE_RC, 1'b0, 26, 1'b1);
        fill_chans();
        send_frame(rclfp_pkg::MIN_LEN, rclfp_pkg::TYPE_RC, 1'b0, 24, 1'b0);
        fill_chans();
        send_frame(8'(rclfp_pkg::MAX_FRAME_DEF), rclfp_pkg::TYPE_RC, 1'b0,
                   rclfp_pkg::MAX_FRAME_DEF, 1'b0);
        // Rejected frames: bad CRC, wrong type, short payloads.
        send_frame(rclfp_pkg::MIN_LEN, rclfp_pkg::TYPE_RC, 1'b1, 24, 1'b0);
        send_frame(rclfp_pkg::MIN_LEN, 8'h17, 1'b0, 24, 1'b0);
        send_frame(8'd23, rclfp_pkg::TYPE_RC, 1'b0, 23, 1'b0);
        send_frame(8'd2, rclfp_pkg::TYPE_RC, 1'b0, 2, 1'b0);
    endtask

    task automatic run_random();
        int unsigned kind;
        logic [7:0] flen;
        logic [7:0] ftype;
        hold_armed = 1'b1;
        while (sent_bytes < 230 || chan_sb.predicted_total < 64) begin
            tx_steady = ($urandom_range(0, 4) == 0);
            kind = $urandom_range(0, 99);
            fill_chans();
            flen = ($urandom_range(0, 9) == 0) ?
                   8'($urandom_range(rclfp_pkg::MIN_LEN, rclfp_pkg::MAX_FRAME_DEF)) :
                   8'($urandom_range(rclfp_pkg::MIN_LEN, rclfp_pkg::MIN_LEN + 4));
            if (kind < 60) begin
                send_frame(flen, rclfp_pkg::TYPE_RC, 1'b0, flen, 1'b0);
            end else if (kind < 68) begin
                send_frame(flen, rclfp_pkg::TYPE_RC, 1'b1, flen, 1'b0);
            end else if (kind < 74) begin
                do ftype = 8'($urandom_range(0, 255)); while (ftype == rclfp_pkg::TYPE_RC);
                send_frame(flen, ftype, 1'b0, flen, 1'b0);
            end else if (kind < 78) begin
                flen = 8'($urandom_range(rclfp_pkg::MIN_BODY, rclfp_pkg::MIN_LEN - 1));
                send_frame(flen, rclfp_pkg::TYPE_RC, 1'b0, flen, 1'b0);
            end else if (kind < 84) begin
                send_byte(rclfp_pkg::SYNC_BYTE);
                if ($urandom_range(0, 1) == 0) send_byte(8'($urandom_range(0, 1)));
                else send_byte(8'($urandom_range(rclfp_pkg::MAX_FRAME_DEF + 1, 255)));
            end else if (kind < 92) begin
                // Cut short: the next frame's bytes land in this body.
                send_frame(flen, rclfp_pkg::TYPE_RC, 1'b0, $urandom_range(0, flen - 1), 1'b0);
            end else begin
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
            end
        end
        tx_steady = 1'b0;
    endtask

    // Receiver side: runs of ready and stalls, plus one long hold-off once the
    // random traffic starts, so the parser has to stall its input.
    initial begin
        i_out_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            int unsigned run;
            logic lvl;
            if (hold_armed && !hold_done) begin
                hold_done = 1'b1;
                lvl = 1'b0;
                run = 400;
            end else if ($urandom_range(0, 9) < 6) begin
                lvl = 1'b1;
                run = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 12);
            end else begin
                lvl = 1'b0;
                run = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 70) : $urandom_range(1, 3);
            end
            @(negedge i_clk);
            i_out_ready <= lvl;
            repeat (run - 1) @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            chan_sb.check_result(o_channel_index, o_pulse_us, o_last_channel);
    end

    initial begin
        chan_sb = new();
        sent_bytes = 0;
        tx_steady = 1'b0;
        hold_armed = 1'b0;
        hold_done = 1'b0;
        i_rst_n = 1'b0;
        i_rx_valid = 1'b0;
        i_rx_byte = 8'h00;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        run_random();
        @(negedge i_clk);
        i_rx_valid <= 1'b0;
        while (chan_sb.pending() != 0) @(posedge i_clk);
        // A rejected frame produces nothing, so give the unpacker time to show
        // any stray request.
        repeat (150) @(posedge i_clk);
        if (chan_sb.pending() != 0)
            chan_sb.flag_mismatch($sformatf("%0d channels never arrived", chan_sb.pending()));
        if (chan_sb.err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
